// ----- hdl/ecsm_pkg.sv -----
// ---------------------------------------------------------------------------
// ecsm_pkg
// Field constants, state and opcode types for the scalar multiplier.
// ---------------------------------------------------------------------------
`default_nettype none
package ecsm_pkg;
  localparam int FW = 48;
  localparam logic [FW-1:0] FIELD_P = 48'd211108170305887;
  localparam logic [FW-1:0] EXP_INV = 48'd211108170305885;
  // floor(2^67 / P), quotient estimate for the digit-step reduction
  localparam logic [19:0] RECIP = 20'((68'd1 << 67) / {20'd0, FIELD_P});

  typedef enum logic [3:0] {
    OP_MUL = 4'b0001,
    OP_ADD = 4'b0010,
    OP_SUB = 4'b0100,
    OP_CPY = 4'b1000
  } op_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RED   = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_PROG  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_INV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  // register file slots
  typedef enum logic [3:0] {
    R_BX, R_BY, R_CX, R_CY, R_X1, R_Y1, R_X2, R_Y2,
    R_T0, R_T1, R_SL, R_X3, R_A, R_K3, R_K2, R_IV
  } reg_t;

  typedef struct packed {
    op_t  op;
    reg_t dst;
    reg_t src_a;
    reg_t src_b;
    logic inv;   // invert dst after the op (dst <= dst^(P-2))
  } uop_t;

  function automatic logic [FW-1:0] mod_red(input logic [FW:0] v);
    logic [FW:0] d;
    d = v - {1'b0, FIELD_P};
    mod_red = d[FW] ? v[FW-1:0] : d[FW-1:0];
  endfunction
endpackage
`default_nettype wire

// ----- hdl/ec_scalar_mult_double_add.sv -----
// A zero scalar goes straight to the output; otherwise a doubling runs for each bit
// of k-1 and an addition for each set bit of k-1.
// A field multiply is issued to the shared multiply-reduce unit as three 16-bit digit
// steps (sum, quotient estimate, remainder, reduction); an inversion raises to P-2.
// One item at a time; ready again the cycle after the result transfer.
// Reset (rst, synchronous) returns to idle and clears curve_a.
// ---------------------------------------------------------------------------
// ec_scalar_mult_double_add
// Affine double-and-add scalar multiplication over a 48-bit prime field.
// ---------------------------------------------------------------------------
`default_nettype none
module ec_scalar_mult_double_add #(
  parameter int SCALAR_BITS = 48
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [47:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [143:0] s_tdata,   // point_x, point_y, scalar
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [95:0]       m_tdata,   // result_x, result_y
  output logic              m_tuser    // zero_scalar
);
  import ecsm_pkg::*;

  localparam int KW = SCALAR_BITS;

  state_t         state;
  logic [FW-1:0]  curve_a;
  logic [FW-1:0]  rf [16];
  logic [KW-1:0]  k;
  logic           pend_add;   // add step pending for current bit
  logic           is_add;     // running program is the add
  logic [4:0]     pc;
  logic [1:0]     dig;
  logic [FW-1:0]  acc;
  logic [5:0]     ecnt;
  logic [FW-1:0]  ib, ir;
  logic           iphase;     // 0: r*=b if bit, 1: b*=b
  logic           ired;

  // multiplier operands
  logic [FW-1:0]  ma, mb;
  logic [1:0]     mph;
  logic [64:0]    sum_r;
  logic [17:0]    q_r;
  logic [48:0]    rem_r;

  assign cfg_ready = (state == S_IDLE);
  assign s_tready  = (state == S_IDLE);

  function automatic uop_t tail(input logic [4:0] i);
    uop_t u;
    u = '{OP_CPY, R_T0, R_T0, R_T0, 1'b0};
    unique case (i)
      5'd0: u = '{OP_MUL, R_T0, R_SL, R_SL, 1'b0};
      5'd1: u = '{OP_SUB, R_T0, R_T0, R_X1, 1'b0};
      5'd2: u = '{OP_SUB, R_X3, R_T0, R_X2, 1'b0};
      5'd3: u = '{OP_SUB, R_T0, R_X1, R_X3, 1'b0};
      5'd4: u = '{OP_MUL, R_T0, R_SL, R_T0, 1'b0};
      5'd5: u = '{OP_SUB, R_T0, R_T0, R_Y1, 1'b0};
      default: u = '{OP_CPY, R_T0, R_T0, R_T0, 1'b0};
    endcase
    return u;
  endfunction

  // micro-program: x1,y1 hold B; x2,y2 hold C (add) or B (double); result into X3/T0, then written to B or C
  uop_t prog;
  logic [4:0] plen;
  always_comb begin
    prog = '{OP_CPY, R_T0, R_T0, R_T0, 1'b0};
    plen = 5'd0;
    if (!is_add) begin
      plen = 5'd11;
      unique case (pc)
        5'd0:  prog = '{OP_MUL, R_T0, R_X1, R_X1, 1'b0};
        5'd1:  prog = '{OP_MUL, R_T0, R_K3, R_T0, 1'b0};
        5'd2:  prog = '{OP_ADD, R_T0, R_T0, R_A, 1'b0};
        5'd3:  prog = '{OP_MUL, R_T1, R_K2, R_Y1, 1'b1};
        5'd4:  prog = '{OP_MUL, R_SL, R_T0, R_T1, 1'b0};
        default: prog = '{OP_CPY, R_T0, R_T0, R_T0, 1'b0};
      endcase
      if (pc >= 5'd5) prog = tail(pc - 5'd5);
    end else begin
      plen = 5'd9;
      unique case (pc)
        5'd0:  prog = '{OP_SUB, R_T0, R_Y2, R_Y1, 1'b0};
        5'd1:  prog = '{OP_SUB, R_T1, R_X2, R_X1, 1'b1};
        5'd2:  prog = '{OP_MUL, R_SL, R_T0, R_T1, 1'b0};
        default: prog = '{OP_CPY, R_T0, R_T0, R_T0, 1'b0};
      endcase
      if (pc >= 5'd3) prog = tail(pc - 5'd3);
    end
  end

  // one 48x16 digit step: acc*2^16 + a*digit, reduced by a reciprocal quotient estimate
  logic [15:0]   dval;
  logic [63:0]   prod;
  logic [64:0]   sum;
  logic [37:0]   qprod;
  logic [64:0]   qp;
  logic [64:0]   remd;
  logic [FW-1:0] step_res;
  assign dval = (dig == 2'd0) ? mb[47:32] : (dig == 2'd1) ? mb[31:16] : mb[15:0];
  assign prod = {16'd0, ma} * {48'd0, dval};
  assign sum  = {1'b0, acc, 16'd0} + {1'b0, prod};
  assign qprod = {20'd0, sum_r[64:47]} * {18'd0, RECIP};
  assign qp = {47'd0, q_r} * {17'd0, FIELD_P};
  assign remd = sum_r - qp;
  assign step_res = mod_red(rem_r);

  logic [FW-1:0] ra, rb;
  assign ra = rf[prog.src_a];
  assign rb = rf[prog.src_b];

  logic [FW:0] addv, subv;
  assign addv = {1'b0, ra} + {1'b0, rb};
  assign subv = {1'b0, ra} + {1'b0, FIELD_P} - {1'b0, rb};

  logic [KW-1:0] k_in;
  assign k_in = KW'(s_tdata[143:96] & 48'((49'd1 << (KW > 48 ? 48 : KW)) - 49'd1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      curve_a <= '0;
      m_tvalid <= 1'b0;
      mph <= 2'd0;
      ired <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) curve_a <= cfg_data;
          if (s_tvalid) begin
            rf[R_BX] <= s_tdata[47:0];
            rf[R_BY] <= s_tdata[95:48];
            rf[R_A]  <= curve_a;
            rf[R_K3] <= 48'd3;
            rf[R_K2] <= 48'd2;
            if (k_in == '0) begin
              m_tdata <= '0; m_tuser <= 1'b1; m_tvalid <= 1'b1;
              state <= S_OUT;
            end else begin
              k <= k_in - KW'(1);
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          rf[R_BX] <= mod_red({1'b0, rf[R_BX]});
          rf[R_BY] <= mod_red({1'b0, rf[R_BY]});
          rf[R_CX] <= mod_red({1'b0, rf[R_BX]});
          rf[R_CY] <= mod_red({1'b0, rf[R_BY]});
          rf[R_A]  <= mod_red({1'b0, rf[R_A]});
          pend_add <= 1'b1;
          state <= S_SCAN;
        end
        S_SCAN: begin
          pc <= '0;
          rf[R_X1] <= rf[R_BX];
          rf[R_Y1] <= rf[R_BY];
          if (k == '0) begin
            m_tdata <= {rf[R_CY], rf[R_CX]}; m_tuser <= 1'b0; m_tvalid <= 1'b1;
            state <= S_OUT;
          end else if (pend_add && k[0]) begin
            is_add <= (rf[R_BX] != rf[R_CX]) || (rf[R_BY] != rf[R_CY]);
            rf[R_X2] <= rf[R_CX]; rf[R_Y2] <= rf[R_CY];
            state <= S_PROG;
          end else begin
            is_add <= 1'b0;
            rf[R_X2] <= rf[R_BX]; rf[R_Y2] <= rf[R_BY];
            pend_add <= 1'b0;
            state <= S_PROG;
          end
        end
        S_PROG: begin
          if (pc == plen) begin
            if (pend_add && k[0]) begin
              rf[R_CX] <= rf[R_X3]; rf[R_CY] <= rf[R_T0];
              pend_add <= 1'b0;
            end else begin
              rf[R_BX] <= rf[R_X3]; rf[R_BY] <= rf[R_T0];
              k <= k >> 1;
              pend_add <= 1'b1;
            end
            state <= S_SCAN;
          end else if (prog.op == OP_MUL) begin
            ma <= ra; mb <= rb; acc <= '0; dig <= '0; mph <= 2'd0;
            state <= S_MUL;
          end else begin
            unique case (prog.op)
              OP_ADD: rf[prog.dst] <= mod_red(addv);
              OP_SUB: rf[prog.dst] <= mod_red(subv);
              default: rf[prog.dst] <= ra;
            endcase
            if (prog.inv) begin
              ib <= (prog.op == OP_ADD) ? mod_red(addv) : mod_red(subv);
              ir <= 48'd1; ecnt <= '0; iphase <= 1'b0; ired <= 1'b0;
              state <= S_INV;
            end else pc <= pc + 5'd1;
          end
        end
        S_MUL: begin
          unique case (mph)
            2'd0: begin
              sum_r <= sum;
              mph <= 2'd1;
            end
            2'd1: begin
              q_r <= qprod[37:20];
              mph <= 2'd2;
            end
            2'd2: begin
              rem_r <= remd[48:0];
              mph <= 2'd3;
            end
            default: begin
              mph <= 2'd0;
              acc <= step_res;
              dig <= dig + 2'd1;
              if (dig == 2'd2) begin
                if (ired) begin
                  if (iphase) ib <= step_res; else ir <= step_res;
                  state <= S_INV;
                end else begin
                  rf[prog.dst] <= step_res;
                  if (prog.inv) begin
                    ib <= step_res; ir <= 48'd1; ecnt <= '0; iphase <= 1'b0;
                    ired <= 1'b0; state <= S_INV;
                  end else begin
                    pc <= pc + 5'd1; state <= S_PROG;
                  end
                end
              end
            end
          endcase
        end
        S_INV: begin
          if (ired) begin
            ired <= 1'b0;
            if (iphase) begin
              iphase <= 1'b0;
              ecnt <= ecnt + 6'd1;
            end else iphase <= 1'b1;
          end else if (ecnt == 6'd48) begin
            rf[prog.dst] <= ir; pc <= pc + 5'd1; state <= S_PROG;
          end else if (!iphase && !EXP_INV[ecnt]) begin
            iphase <= 1'b1;
          end else begin
            ma <= iphase ? ib : ir; mb <= ib; acc <= '0; dig <= '0; mph <= 2'd0;
            ired <= 1'b1; state <= S_MUL;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/ecsm_checker.sv -----
// ---------------------------------------------------------------------------
// ecsm_checker
// Port-level assertions for the scalar multiplier.
// ---------------------------------------------------------------------------
`default_nettype none
module ecsm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [95:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        cfg_ready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken with result pending");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0) else $error("zero scalar data");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_ready == s_tready) else $error("config ready mismatch");
  a_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("ready held after transfer");
endmodule

bind ec_scalar_mult_double_add ecsm_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
  .m_tuser(m_tuser), .cfg_ready(cfg_ready)
);
`default_nettype wire

// ----- tb/ec_scalar_mult_double_add_tb.sv -----
// ---------------------------------------------------------------------------
// ec_scalar_mult_double_add_tb
// Self-checking bench for the double-and-add scalar multiplier. Points and
// scalars stream in over the slave side. Each result is checked against an
// in-bench affine model, under several values of curve_a, with random
// idling on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ec_scalar_mult_double_add_tb;
  import ecsm_pkg::*;

  localparam bit [63:0] PRIME = 64'd211108170305887;
  localparam bit [47:0] ALL1 = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    bit [47:0] x;
    bit [47:0] y;
    bit [47:0] k;
  } point_job_t;

  typedef struct {
    bit [47:0] rx;
    bit [47:0] ry;
    bit        zs;
  } mult_result_t;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [47:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [143:0] s_tdata;   // point_x, point_y, scalar
  logic         m_tvalid;
  logic         m_tready;
  logic [95:0]  m_tdata;   // result_x, result_y
  logic         m_tuser;   // zero_scalar

  point_job_t   job_q[$];
  mult_result_t product_q[$];
  point_job_t   cur_job;
  bit [47:0]    coef_a;
  bit           quiet;
  int           errors;

  ec_scalar_mult_double_add uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  function automatic bit [63:0] fld_mul(bit [63:0] x, bit [63:0] y);
    bit [63:0] acc;
    bit [63:0] digit;
    acc = 0;
    for (int s = 32; s >= 0; s -= 16) begin
      digit = (y >> s) & 64'hFFFF;
      acc = (acc << 16) % PRIME;
      acc = (acc + (x * digit) % PRIME) % PRIME;
    end
    return acc;
  endfunction

  function automatic bit [63:0] fld_sub(bit [63:0] x, bit [63:0] y);
    return (x + PRIME - y) % PRIME;
  endfunction

  function automatic bit [63:0] fld_inv(bit [63:0] u);
    bit [63:0] e;
    bit [63:0] r;
    bit [63:0] b;
    e = PRIME - 2;
    r = 1;
    b = u;
    while (e != 0) begin
      if (e[0]) r = fld_mul(r, b);
      b = fld_mul(b, b);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic void pt_add(bit [63:0] x1, bit [63:0] y1, bit [63:0] x2,
                                 bit [63:0] y2, bit [63:0] a,
                                 output bit [63:0] xo, output bit [63:0] yo);
    bit [63:0] slope;
    bit [63:0] num;
    bit [63:0] x3;
    if (x1 == x2 && y1 == y2) begin
      num = (fld_mul(3, fld_mul(x1, x1)) + a) % PRIME;
      slope = fld_mul(num, fld_inv(fld_mul(2, y1)));
    end else begin
      slope = fld_mul(fld_sub(y2, y1), fld_inv(fld_sub(x2, x1)));
    end
    x3 = fld_sub(fld_sub(fld_mul(slope, slope), x1), x2);
    yo = fld_sub(fld_mul(slope, fld_sub(x1, x3)), y1);
    xo = x3;
  endfunction

  function automatic mult_result_t scalar_product(point_job_t j, bit [47:0] a);
    mult_result_t res;
    bit [63:0] bx, by, cx, cy, am, k;
    bx = {16'd0, j.x} % PRIME;
    by = {16'd0, j.y} % PRIME;
    am = {16'd0, a} % PRIME;
    k = {16'd0, j.k};
    if (k == 0) begin
      res.rx = 0;
      res.ry = 0;
      res.zs = 1;
      return res;
    end
    cx = bx;
    cy = by;
    k = k - 1;
    while (k != 0) begin
      if (k[0]) pt_add(bx, by, cx, cy, am, cx, cy);
      pt_add(bx, by, bx, by, am, bx, by);
      k = k >> 1;
    end
    res.rx = cx[47:0];
    res.ry = cy[47:0];
    res.zs = 0;
    return res;
  endfunction

  task automatic report_mismatch(string what, bit [47:0] got, bit [47:0] want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready) product_q.push_back(scalar_product(cur_job, coef_a));
      if (!s_tvalid || s_tready) begin
        if (job_q.size() != 0 && (quiet || $urandom_range(99) >= 33)) begin
          cur_job = job_q.pop_front();
          s_tdata <= {cur_job.k, cur_job.y, cur_job.x};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    mult_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (product_q.size() == 0) begin
          report_mismatch("unexpected result transfer", m_tdata[47:0], 48'd0);
        end else begin
          want = product_q.pop_front();
          if (m_tdata[47:0] !== want.rx) report_mismatch("result_x", m_tdata[47:0], want.rx);
          if (m_tdata[95:48] !== want.ry) report_mismatch("result_y", m_tdata[95:48], want.ry);
          if (m_tuser !== want.zs)
            report_mismatch("zero_scalar", {47'd0, m_tuser}, {47'd0, want.zs});
        end
      end
      m_tready <= quiet || ($urandom_range(99) >= 33);
    end
  end

  task automatic write_coef(bit [47:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    coef_a = v;
  endtask

  task automatic drain();
    wait (job_q.size() == 0 && !s_tvalid && product_q.size() == 0);
    @(posedge clk);
  endtask

  function automatic bit [47:0] rnd48();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic add_job(bit [47:0] x, bit [47:0] y, bit [47:0] k);
    point_job_t j;
    j.x = x;
    j.y = y;
    j.k = k;
    job_q.push_back(j);
  endtask

  task automatic add_random(int n, int wide);
    bit [47:0] k;
    for (int i = 0; i < n; i++) begin
      if (i < wide) k = rnd48();
      else if ($urandom_range(19) == 0) k = 0;
      else k = 48'($urandom_range(31, 1));
      add_job(rnd48(), rnd48(), k);
    end
  endtask

  initial begin
    bit [47:0] coefs[5];
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    coef_a = 0;
    quiet = 0;
    errors = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    coefs[0] = 0;
    coefs[1] = FIELD_P - 1;
    coefs[2] = ALL1;
    coefs[3] = 3;
    coefs[4] = rnd48() % FIELD_P;

    write_coef(coefs[0]);
    add_job(0, 0, 0);
    add_job(ALL1, ALL1, 0);
    add_job(12345, 67890, 1);
    add_job(ALL1, ALL1, 1);
    add_job(FIELD_P, FIELD_P - 1, 1);
    add_job(FIELD_P - 1, FIELD_P - 1, 2);
    add_job(5, 0, 2);
    add_job(0, 0, 3);
    add_job(7, 11, 3);
    add_job(ALL1, 1, 5);
    add_job(rnd48(), rnd48(), ALL1);
    add_job(rnd48(), rnd48(), 48'h8000_0000_0000);
    add_job(rnd48(), 0, 4);
    add_job(1, 2, 31);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_coef(coefs[p]);
      quiet = (p == 2);
      add_job(rnd48(), 0, 2);
      add_random(17, (p < 3) ? 1 : 0);
      drain();
    end
    quiet = 0;

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hdl/ecsm_pkg.sv
hdl/ec_scalar_mult_double_add.sv
hdl/ecsm_checker.sv
tb/ec_scalar_mult_double_add_tb.sv
